/* rtl/srdm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdm_pkg
// Shared types and constants of the radial deadzone magnitude pipeline:
// transaction payloads, side-band records and pipeline geometry.
// ----------------------------------------------------------------------------
package srdm_pkg;

    // field widths
    localparam int AXIS_W = 16;
    localparam int SEL_W  = 2;
    localparam int DZ_W   = 15;
    localparam int FRAC_W = 16;

    // full-scale axis magnitude, the clamp for the root
    localparam logic [DZ_W-1:0] AXIS_FULL_SCALE = 15'd32767;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 16'hFFFF;

    // squared radius and its root
    localparam int RAD_W  = 2 * AXIS_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // pipeline geometry: root and quotient bits resolved per register stage
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = FRAC_W / DIV_STEPS;

    // stick select codes
    localparam logic [SEL_W-1:0] SEL_LEFT  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_RIGHT = 2'd1;
    localparam logic [SEL_W-1:0] SEL_NONE  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_DZ  = 1'b0,
        CFG_RIGHT_DZ = 1'b1
    } t_cfg_reg;

    // how the final result is formed
    typedef enum logic [1:0] {
        RK_INSIDE = 2'd0,
        RK_ZERO   = 2'd1,
        RK_FULL   = 2'd2,
        RK_QUOT   = 2'd3
    } t_res_kind;

    typedef struct packed {
        logic signed [AXIS_W-1:0] stick_x;
        logic signed [AXIS_W-1:0] stick_y;
        logic        [SEL_W-1:0]  stick_select;
    } t_stick_cmd;

    typedef struct packed {
        logic [FRAC_W-1:0] magnitude_fraction;
        logic              in_deadzone;
    } t_stick_res;

    // side-band carried alongside the root pipeline
    typedef struct packed {
        logic [DZ_W-1:0] dz;
        logic            in_dz;
    } t_sq_side;

endpackage

/* rtl/srdm_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdm_isqrt
// Pipelined floor square root of a 32-bit radicand, restoring bit-pair
// method, a fixed number of root bits per stage, side-band passed along.
// ----------------------------------------------------------------------------
module srdm_isqrt import srdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_sq_side          i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_side          o_side
);

    localparam int LAST = SQRT_STAGES - 1;

    logic              r_vld  [SQRT_STAGES];
    logic [RAD_W-1:0]  r_rad  [SQRT_STAGES];
    logic [REM_W-1:0]  r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];
    t_sq_side          r_side [SQRT_STAGES];

    logic              w_src_vld  [SQRT_STAGES];
    logic [RAD_W-1:0]  w_src_rad  [SQRT_STAGES];
    logic [REM_W-1:0]  w_src_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] w_src_root [SQRT_STAGES];
    t_sq_side          w_src_side [SQRT_STAGES];

    logic [RAD_W-1:0]  n_rad  [SQRT_STAGES];
    logic [REM_W-1:0]  n_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] n_root [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        // stage source: module inputs or the previous stage
        if (g == 0) begin : g_first
            assign w_src_vld[g]  = i_vld;
            assign w_src_rad[g]  = i_rad;
            assign w_src_rem[g]  = '0;
            assign w_src_root[g] = '0;
            assign w_src_side[g] = i_side;
        end else begin : g_next
            assign w_src_vld[g]  = r_vld[g-1];
            assign w_src_rad[g]  = r_rad[g-1];
            assign w_src_rem[g]  = r_rem[g-1];
            assign w_src_root[g] = r_root[g-1];
            assign w_src_side[g] = r_side[g-1];
        end

        // resolve a few root bits, two radicand bits each
        always_comb begin : p_steps
            logic [RAD_W-1:0]  v_rad;
            logic [REM_W-1:0]  v_rem;
            logic [REM_W-1:0]  v_sh;
            logic [REM_W-1:0]  v_trial;
            logic [ROOT_W-1:0] v_root;
            v_rad  = w_src_rad[g];
            v_rem  = w_src_rem[g];
            v_root = w_src_root[g];
            for (int k = 0; k < SQRT_STEPS; k++) begin
                v_sh    = {v_rem[REM_W-3:0], v_rad[RAD_W-1 -: 2]};
                v_trial = {v_root, 2'b01};
                if (v_sh >= v_trial) begin
                    v_rem  = v_sh - v_trial;
                    v_root = {v_root[ROOT_W-2:0], 1'b1};
                end else begin
                    v_rem  = v_sh;
                    v_root = {v_root[ROOT_W-2:0], 1'b0};
                end
                v_rad = {v_rad[RAD_W-3:0], 2'b00};
            end
            n_rad[g]  = v_rad;
            n_rem[g]  = v_rem;
            n_root[g] = v_root;
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_src_vld[g];
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            r_rad[g]  <= n_rad[g];
            r_rem[g]  <= n_rem[g];
            r_root[g] <= n_root[g];
            r_side[g] <= w_src_side[g];
        end
    end

    assign o_vld  = r_vld[LAST];
    assign o_root = r_root[LAST];
    assign o_side = r_side[LAST];

endmodule

/* rtl/srdm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdm_div
// Pipelined restoring divider for the Q0.16 fraction: quotient of
// (dividend << 16) / divisor with dividend below divisor.
// ----------------------------------------------------------------------------
module srdm_div import srdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [DZ_W-1:0]   i_num,
    input  logic [DZ_W-1:0]   i_den,
    input  t_res_kind         i_kind,
    output logic              o_vld,
    output logic [FRAC_W-1:0] o_quot,
    output t_res_kind         o_kind
);

    localparam int LAST = DIV_STAGES - 1;

    logic              r_vld  [DIV_STAGES];
    logic [DZ_W-1:0]   r_rem  [DIV_STAGES];
    logic [DZ_W-1:0]   r_den  [DIV_STAGES];
    logic [FRAC_W-1:0] r_quot [DIV_STAGES];
    t_res_kind         r_kind [DIV_STAGES];

    logic              w_src_vld  [DIV_STAGES];
    logic [DZ_W-1:0]   w_src_rem  [DIV_STAGES];
    logic [DZ_W-1:0]   w_src_den  [DIV_STAGES];
    logic [FRAC_W-1:0] w_src_quot [DIV_STAGES];
    t_res_kind         w_src_kind [DIV_STAGES];

    logic [DZ_W-1:0]   n_rem  [DIV_STAGES];
    logic [FRAC_W-1:0] n_quot [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        // stage source: module inputs or the previous stage
        if (g == 0) begin : g_first
            assign w_src_vld[g]  = i_vld;
            assign w_src_rem[g]  = i_num;
            assign w_src_den[g]  = i_den;
            assign w_src_quot[g] = '0;
            assign w_src_kind[g] = i_kind;
        end else begin : g_next
            assign w_src_vld[g]  = r_vld[g-1];
            assign w_src_rem[g]  = r_rem[g-1];
            assign w_src_den[g]  = r_den[g-1];
            assign w_src_quot[g] = r_quot[g-1];
            assign w_src_kind[g] = r_kind[g-1];
        end

        // shift-compare-subtract, one quotient bit per step
        always_comb begin : p_steps
            logic [DZ_W-1:0]   v_rem;
            logic [DZ_W:0]     v_sh;
            logic [DZ_W:0]     v_diff;
            logic [FRAC_W-1:0] v_quot;
            v_rem  = w_src_rem[g];
            v_quot = w_src_quot[g];
            for (int k = 0; k < DIV_STEPS; k++) begin
                v_sh   = {v_rem, 1'b0};
                v_diff = v_sh - {1'b0, w_src_den[g]};
                if (v_sh >= {1'b0, w_src_den[g]}) begin
                    v_rem  = v_diff[DZ_W-1:0];
                    v_quot = {v_quot[FRAC_W-2:0], 1'b1};
                end else begin
                    v_rem  = v_sh[DZ_W-1:0];
                    v_quot = {v_quot[FRAC_W-2:0], 1'b0};
                end
            end
            n_rem[g]  = v_rem;
            n_quot[g] = v_quot;
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_src_vld[g];
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem[g];
            r_den[g]  <= w_src_den[g];
            r_quot[g] <= n_quot[g];
            r_kind[g] <= w_src_kind[g];
        end
    end

    assign o_vld  = r_vld[LAST];
    assign o_quot = r_quot[LAST];
    assign o_kind = r_kind[LAST];

endmodule

/* rtl/stick_radial_deadzone_magnitude.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_radial_deadzone_magnitude
// Radial deadzone normalization of an analog stick position into an
// unsigned Q0.16 magnitude fraction beyond the selected deadzone.
// ----------------------------------------------------------------------------
// The block takes a new transaction in every clock cycle (busy stays low) and
// returns its result on o_res, marked by o_res_strobe for one cycle, after the
// pipeline: squaring, radius compare, four stages of floor square root, one
// setup stage, four stages of quotient (four bits per stage each) and the
// output register. Deadzone writes are always ready and take effect for
// transactions accepted after the write.
// ----------------------------------------------------------------------------
module stick_radial_deadzone_magnitude import srdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  t_stick_cmd           i_cmd,
    // result channel
    output logic                 o_res_strobe,
    output t_stick_res           o_res,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DZ_W-1:0]      i_cfg_data
);

    localparam int LATENCY = 2 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    logic [DZ_W-1:0] r_left_dz;
    logic [DZ_W-1:0] r_right_dz;

    logic                    w_accept;
    logic [DZ_W-1:0]         w_dz_sel;
    logic signed [RAD_W-1:0] w_xsq_full;
    logic signed [RAD_W-1:0] w_ysq_full;
    logic [2*DZ_W-1:0]       w_dzsq;

    logic                r_s1_vld;
    logic [RAD_W-2:0]    r_s1_xsq;
    logic [RAD_W-2:0]    r_s1_ysq;
    logic [2*DZ_W-1:0]   r_s1_dzsq;
    logic [DZ_W-1:0]     r_s1_dz;
    logic                r_s1_none;

    logic [RAD_W-1:0]    w_r2;
    logic                r_s2_vld;
    logic [RAD_W-1:0]    r_s2_r2;
    t_sq_side            r_s2_side;

    logic                w_sq_vld;
    logic [ROOT_W-1:0]   w_root;
    t_sq_side            w_sq_side;

    logic [DZ_W-1:0]     w_mag;
    logic [DZ_W-1:0]     w_num;
    logic [DZ_W-1:0]     w_den;
    t_res_kind           w_kind;
    logic                r_s3_vld;
    logic [DZ_W-1:0]     r_s3_num;
    logic [DZ_W-1:0]     r_s3_den;
    t_res_kind           r_s3_kind;

    logic                w_div_vld;
    logic [FRAC_W-1:0]   w_quot;
    t_res_kind           w_div_kind;
    t_stick_res          n_res;
    logic                r_res_vld;
    t_stick_res          r_res;

    // handshakes: a transaction enters every cycle
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // deadzone registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz  <= 15'd7849;
            r_right_dz <= 15'd8689;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LEFT_DZ:  r_left_dz  <= i_cfg_data;
                CFG_RIGHT_DZ: r_right_dz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: squares of both axes and of the selected deadzone
    always_comb begin
        case (i_cmd.stick_select)
            SEL_LEFT:  w_dz_sel = r_left_dz;
            SEL_RIGHT: w_dz_sel = r_right_dz;
            default:   w_dz_sel = '0;
        endcase
    end

    assign w_xsq_full = $signed(i_cmd.stick_x) * $signed(i_cmd.stick_x);
    assign w_ysq_full = $signed(i_cmd.stick_y) * $signed(i_cmd.stick_y);
    assign w_dzsq     = w_dz_sel * w_dz_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_xsq  <= w_xsq_full[RAD_W-2:0];
        r_s1_ysq  <= w_ysq_full[RAD_W-2:0];
        r_s1_dzsq <= w_dzsq;
        r_s1_dz   <= w_dz_sel;
        r_s1_none <= (i_cmd.stick_select != SEL_LEFT) && (i_cmd.stick_select != SEL_RIGHT);
    end

    // stage 2: squared radius and deadzone compare (edge counts as inside)
    assign w_r2 = {1'b0, r_s1_xsq} + {1'b0, r_s1_ysq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_r2         <= w_r2;
        r_s2_side.dz    <= r_s1_dz;
        r_s2_side.in_dz <= r_s1_none || (w_r2 <= {2'b00, r_s1_dzsq});
    end

    // floor square root
    srdm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_rad   (r_s2_r2),
        .i_side  (r_s2_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // clamp, subtract the deadzone and classify the result
    assign w_mag = (w_root > {1'b0, AXIS_FULL_SCALE}) ? AXIS_FULL_SCALE : w_root[DZ_W-1:0];
    assign w_num = w_mag - w_sq_side.dz;
    assign w_den = AXIS_FULL_SCALE - w_sq_side.dz;

    always_comb begin
        if (w_sq_side.in_dz) begin
            w_kind = RK_INSIDE;
        end else if (w_sq_side.dz == AXIS_FULL_SCALE) begin
            w_kind = RK_FULL;
        end else if (w_mag <= w_sq_side.dz) begin
            w_kind = RK_ZERO;
        end else if (w_num == w_den) begin
            // ratio of exactly one saturates
            w_kind = RK_FULL;
        end else begin
            w_kind = RK_QUOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_num  <= w_num;
        r_s3_den  <= w_den;
        r_s3_kind <= w_kind;
    end

    // fraction of the remaining travel
    srdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_num   (r_s3_num),
        .i_den   (r_s3_den),
        .i_kind  (r_s3_kind),
        .o_vld   (w_div_vld),
        .o_quot  (w_quot),
        .o_kind  (w_div_kind)
    );

    // result select
    always_comb begin
        unique case (w_div_kind)
            RK_INSIDE: n_res = '{magnitude_fraction: '0,       in_deadzone: 1'b1};
            RK_ZERO:   n_res = '{magnitude_fraction: '0,       in_deadzone: 1'b0};
            RK_FULL:   n_res = '{magnitude_fraction: FRAC_MAX, in_deadzone: 1'b0};
            RK_QUOT:   n_res = '{magnitude_fraction: w_quot,   in_deadzone: 1'b0};
            default:   n_res = '{magnitude_fraction: '0,       in_deadzone: 1'b1};
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_strobe = r_res_vld;
    assign o_res        = r_res;

`ifndef SYNTH
    // every result traces back to an accepted transaction
    a_res_has_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching transaction");

    // every accepted transaction yields a result after the fixed latency
    a_cmd_has_res : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_res_strobe)
        else $error("transaction produced no result");

    // a deadzone result carries a zero fraction
    a_dz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.in_deadzone) |-> (o_res.magnitude_fraction == '0))
        else $error("nonzero fraction inside the deadzone");

    // an unselected stick always lands in the deadzone
    a_none_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.stick_select != SEL_LEFT) && (i_cmd.stick_select != SEL_RIGHT))
        |-> ##LATENCY o_res.in_deadzone)
        else $error("select none did not report deadzone");
`endif

endmodule
